/* rtl/srcs_pkg.sv */
// shared types, widths and defaults for the selective-repeat chunk sender
`default_nettype none

package srcs_pkg;

    localparam int SEQ_W      = 20;
    localparam int BYTES_W    = 31;
    localparam int KIND_W     = 2;
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 56;

    localparam int WINDOW_SLOTS_DEF = 8;
    localparam int CHUNK_BYTES_DEF  = 2048;

    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_ACK    = 2'd0,
        REQ_RESUME = 2'd1,
        REQ_TICK   = 2'd2
    } req_type_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND     = 2'd0,
        KIND_RETX     = 2'd1,
        KIND_PROGRESS = 2'd2,
        KIND_DONE     = 2'd3
    } res_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_UPLOAD   = 2'd1,
        MODE_FINISHED = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        MUL_ACK  = 2'd0,
        MUL_CUM  = 2'd1,
        MUL_BASE = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic      capture;
        logic      mul_start;
        mul_sel_t  mul_sel;
        logic      ack_mark;
        logic      prog_max;
        logic      slide;
        logic      clear_marks;
        logic      res_set;
        logic      set_finished;
        logic      scan_load;
        logic      scan_send;
        logic      scan_step;
        logic      emit;
        logic      emit_chunk;
        res_kind_t emit_kind;
        logic      emit_last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       resp_ok;
        logic       fin_reached;
        logic       cum_eq_final;
        logic       uploading;
        logic       send_any;
        logic       retx_any;
        logic       head_acked;
        logic       pend_head;
        logic       pend_rest_zero;
        logic       out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/srcs_dp.sv */
// datapath: window state, marks, shared multiplier, scan registers and output register
`default_nettype none

module srcs_dp #(
    parameter int WINDOW_SLOTS = srcs_pkg::WINDOW_SLOTS_DEF,
    parameter int CHUNK_BYTES  = srcs_pkg::CHUNK_BYTES_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire [srcs_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire [srcs_pkg::IN_USER_W-1:0]    s_tuser,
    input  wire srcs_pkg::cmd_t              cmd,
    output srcs_pkg::status_t                stat,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [srcs_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [srcs_pkg::KIND_W-1:0]      m_tuser,
    output logic                             m_tlast
);

    localparam int SEQ_W   = srcs_pkg::SEQ_W;
    localparam int BYTES_W = srcs_pkg::BYTES_W;
    localparam int W       = WINDOW_SLOTS;
    localparam int CB_W    = $clog2(CHUNK_BYTES + 1);
    localparam int PROD_W  = SEQ_W + 1 + CB_W;
    localparam logic [CB_W-1:0] CB = CB_W'(CHUNK_BYTES);

    // captured input beat
    logic [1:0]         req_reg;
    logic               ok_reg;
    logic [SEQ_W-1:0]   ack_reg;
    logic [SEQ_W-1:0]   cum_reg;
    logic [SEQ_W-1:0]   fin_reg;
    logic [BYTES_W-1:0] fbytes_reg;

    // sender state
    logic [SEQ_W-1:0]   base_reg;
    logic [SEQ_W-1:0]   final_reg;
    logic [BYTES_W-1:0] total_reg;
    logic [BYTES_W-1:0] progress_reg;
    logic [W-1:0]       acked_reg;
    logic [W-1:0]       outst_reg;
    srcs_pkg::mode_t    mode_reg;

    // scan
    logic [PROD_W-1:0]  prod_reg;
    logic [W-1:0]       pend_reg;
    logic [SEQ_W-1:0]   scan_seq_reg;

    // output register
    logic               out_valid_reg;

    logic [srcs_pkg::KIND_W-1:0] out_kind_reg;
    logic [SEQ_W-1:0]   out_seq_reg;
    logic [BYTES_W-1:0] out_bytes_reg;
    logic               out_last_reg;

    logic [SEQ_W:0]     mul_a;
    logic [PROD_W-1:0]  prod_mul;
    logic [BYTES_W-1:0] sat_prod;
    logic [BYTES_W-1:0] chunk_bytes;
    logic [SEQ_W-1:0]   ack_diff;
    logic               ack_in_win;
    logic [W-1:0]       ack_onehot;
    logic [W-1:0]       range_mask;
    logic [W-1:0]       send_mask;
    logic [W-1:0]       retx_mask;
    logic               out_free;

    always_comb begin
        case (cmd.mul_sel)
            srcs_pkg::MUL_ACK:  mul_a = {1'b0, ack_reg};
            srcs_pkg::MUL_CUM:  mul_a = {1'b0, cum_reg};
            srcs_pkg::MUL_BASE: mul_a = {1'b0, base_reg};
            default:            mul_a = '0;
        endcase
    end

    assign prod_mul = PROD_W'(mul_a) * PROD_W'(CB);

    assign sat_prod    = (prod_reg > PROD_W'(srcs_pkg::BYTES_MAX)) ? srcs_pkg::BYTES_MAX
                                                                   : prod_reg[BYTES_W-1:0];
    assign chunk_bytes = (prod_reg > PROD_W'(total_reg)) ? total_reg : prod_reg[BYTES_W-1:0];

    assign ack_diff   = ack_reg - base_reg;
    assign ack_in_win = (ack_reg >= base_reg) && (ack_diff < SEQ_W'(W));

    always_comb begin
        for (int i = 0; i < W; i++) begin
            ack_onehot[i] = ack_in_win && (ack_diff == SEQ_W'(i));
            range_mask[i] = (({1'b0, base_reg} + (SEQ_W + 1)'(i)) <= {1'b0, final_reg});
        end
    end

    assign send_mask = range_mask & ~acked_reg & ~outst_reg;
    assign retx_mask = range_mask & ~acked_reg & outst_reg;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        stat.req_type       = req_reg;
        stat.resp_ok        = ok_reg;
        stat.fin_reached    = (cum_reg >= fin_reg);
        stat.cum_eq_final   = (final_reg == cum_reg);
        stat.uploading      = (mode_reg == srcs_pkg::MODE_UPLOAD);
        stat.send_any       = |send_mask;
        stat.retx_any       = |retx_mask;
        stat.head_acked     = acked_reg[0];
        stat.pend_head      = pend_reg[0];
        stat.pend_rest_zero = ((pend_reg >> 1) == '0);
        stat.out_free       = out_free;
    end

    // input capture, multiplier result and scan sequence, no reset
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ack_reg    <= s_tdata[19:0];
            cum_reg    <= s_tdata[39:20];
            fin_reg    <= s_tdata[59:40];
            fbytes_reg <= s_tdata[90:60];
            req_reg    <= s_tuser[1:0];
            ok_reg     <= s_tuser[2];
        end
        if (cmd.mul_start) begin
            prod_reg <= prod_mul;
        end else if (cmd.scan_step) begin
            prod_reg <= prod_reg + PROD_W'(CB);
        end
        if (cmd.scan_load) begin
            scan_seq_reg <= base_reg;
        end else if (cmd.scan_step) begin
            scan_seq_reg <= scan_seq_reg + SEQ_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= SEQ_W'(1);
            final_reg    <= '0;
            total_reg    <= '0;
            progress_reg <= '0;
            acked_reg    <= '0;
            outst_reg    <= '0;
            mode_reg     <= srcs_pkg::MODE_IDLE;
            pend_reg     <= '0;
        end else begin
            if (cmd.ack_mark) begin
                acked_reg <= acked_reg | ack_onehot;
                outst_reg <= outst_reg & ~ack_onehot;
            end else if (cmd.slide) begin
                acked_reg <= acked_reg >> 1;
                outst_reg <= outst_reg >> 1;
                base_reg  <= base_reg + SEQ_W'(1);
            end else if (cmd.clear_marks) begin
                acked_reg <= '0;
                outst_reg <= '0;
            end else if (cmd.scan_load && cmd.scan_send) begin
                outst_reg <= outst_reg | send_mask;
            end
            if (cmd.prog_max && (sat_prod > progress_reg)) begin
                progress_reg <= sat_prod;
            end
            if (cmd.res_set) begin
                base_reg     <= cum_reg + SEQ_W'(1);
                final_reg    <= fin_reg;
                total_reg    <= fbytes_reg;
                progress_reg <= sat_prod;
                mode_reg     <= srcs_pkg::MODE_UPLOAD;
            end
            if (cmd.set_finished) begin
                mode_reg <= srcs_pkg::MODE_FINISHED;
            end
            if (cmd.scan_load) begin
                pend_reg <= cmd.scan_send ? send_mask : retx_mask;
            end else if (cmd.scan_step) begin
                pend_reg <= pend_reg >> 1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_kind_reg <= cmd.emit_kind;
            out_last_reg <= cmd.emit_last;
            if (cmd.emit_chunk) begin
                out_seq_reg   <= scan_seq_reg;
                out_bytes_reg <= chunk_bytes;
            end else begin
                out_seq_reg   <= '0;
                out_bytes_reg <= progress_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(srcs_pkg::OUT_DATA_W - SEQ_W - BYTES_W){1'b0}}, out_bytes_reg,
                       out_seq_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* rtl/srcs_ctrl.sv */
// controller state machine sequencing acknowledgement, resume and tick handling
`default_nettype none

module srcs_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire srcs_pkg::status_t  stat,
    output srcs_pkg::cmd_t          cmd
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_DECODE   = 11'b000_0000_0010,
        ST_ACK_MUL  = 11'b000_0000_0100,
        ST_ACK_PROG = 11'b000_0000_1000,
        ST_SLIDE    = 11'b000_0001_0000,
        ST_REPORT   = 11'b000_0010_0000,
        ST_DONE     = 11'b000_0100_0000,
        ST_RES_MUL  = 11'b000_1000_0000,
        ST_RES_SET  = 11'b001_0000_0000,
        ST_SCAN_MUL = 11'b010_0000_0000,
        ST_SCAN     = 11'b100_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    srcs_pkg::res_kind_t kind_reg, kind_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= srcs_pkg::KIND_SEND;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!stat.resp_ok) begin
                    state_next = ST_IDLE;
                end else begin
                    unique case (stat.req_type)
                        srcs_pkg::REQ_ACK: begin
                            state_next = ST_ACK_MUL;
                        end
                        srcs_pkg::REQ_RESUME: begin
                            cmd.clear_marks = 1'b1;
                            state_next = stat.fin_reached ? ST_DONE : ST_RES_MUL;
                        end
                        srcs_pkg::REQ_TICK: begin
                            if (stat.uploading && stat.retx_any) begin
                                kind_next  = srcs_pkg::KIND_RETX;
                                state_next = ST_SCAN_MUL;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACK_MUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = srcs_pkg::MUL_ACK;
                cmd.ack_mark  = 1'b1;
                state_next    = ST_ACK_PROG;
            end
            ST_ACK_PROG: begin
                cmd.prog_max = 1'b1;
                state_next   = ST_SLIDE;
            end
            ST_SLIDE: begin
                if (stat.head_acked) begin
                    cmd.slide = 1'b1;
                end else begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (stat.cum_eq_final) begin
                    state_next = ST_DONE;
                end else if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = srcs_pkg::KIND_PROGRESS;
                    cmd.emit_last = !(stat.uploading && stat.send_any);
                    if (stat.uploading && stat.send_any) begin
                        kind_next  = srcs_pkg::KIND_SEND;
                        state_next = ST_SCAN_MUL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.emit         = 1'b1;
                    cmd.emit_kind    = srcs_pkg::KIND_DONE;
                    cmd.emit_last    = 1'b1;
                    cmd.set_finished = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_RES_MUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = srcs_pkg::MUL_CUM;
                state_next    = ST_RES_SET;
            end
            ST_RES_SET: begin
                cmd.res_set = 1'b1;
                kind_next   = srcs_pkg::KIND_SEND;
                state_next  = ST_SCAN_MUL;
            end
            ST_SCAN_MUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = srcs_pkg::MUL_BASE;
                cmd.scan_load = 1'b1;
                cmd.scan_send = (kind_reg == srcs_pkg::KIND_SEND);
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                if (!stat.pend_head) begin
                    cmd.scan_step = 1'b1;
                end else if (stat.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_chunk = 1'b1;
                    cmd.emit_kind  = kind_reg;
                    cmd.emit_last  = stat.pend_rest_zero;
                    cmd.scan_step  = 1'b1;
                    if (stat.pend_rest_zero) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/selective_repeat_chunk_sender_unit.sv */
// top level of the selective-repeat chunk sender: controller plus datapath
// one item at a time; s_tready is high only while the controller is idle
// ack: decode, multiply and mark, progress, slide acked head slots, report, then scan when sending
// resume: clear marks, multiply, set state, scan, or done if complete; tick: retx scan or idle
// at most one result per cycle through a single output register; m_tready low stalls the scan
// sync active-low reset: base 1, final, total, progress, marks, mode cleared; no results pending
`default_nettype none

module selective_repeat_chunk_sender_unit #(
    parameter int WINDOW_SLOTS = srcs_pkg::WINDOW_SLOTS_DEF,
    parameter int CHUNK_BYTES  = srcs_pkg::CHUNK_BYTES_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input beat
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // ack_seq[19:0], cum_ack[39:20], final_chunk[59:40], file_bytes[90:60], zero pad
    input  wire [srcs_pkg::IN_DATA_W-1:0]    s_tdata,
    // req_type[1:0], resp_ok[2]
    input  wire [srcs_pkg::IN_USER_W-1:0]    s_tuser,
    // result beat
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // chunk_seq[19:0], byte_count[50:20], zero pad
    output logic [srcs_pkg::OUT_DATA_W-1:0]  m_tdata,
    // res_kind[1:0]
    output logic [srcs_pkg::KIND_W-1:0]      m_tuser,
    // last result of the input beat
    output logic                             m_tlast
);

    // command and status between controller and datapath
    srcs_pkg::cmd_t    ctrl_cmd;
    srcs_pkg::status_t dp_stat;

    // sequencer: decode, slide loop, report, window scan
    srcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    // window state, marks, chunk byte multiplier and output register
    srcs_dp #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .CHUNK_BYTES  (CHUNK_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (ctrl_cmd),
        .stat     (dp_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
